### rtl/mfrs_pkg.sv
// Shared types and codes for the monochrome frame store with region scroll.
// No dependencies; mfrs_exec, mfrs_seq and the top level import this package.
`default_nettype none

package mfrs_pkg;

	// Extended address width: covers the largest store and every scroll address
	localparam int EXT_AW = 17;

	// Item modes
	localparam logic [1:0] MODE_WRITE  = 2'd0;
	localparam logic [1:0] MODE_READ   = 2'd1;
	localparam logic [1:0] MODE_SCROLL = 2'd2;

	// Scroll directions
	localparam logic [1:0] DIR_UP    = 2'd0;
	localparam logic [1:0] DIR_DOWN  = 2'd1;
	localparam logic [1:0] DIR_RIGHT = 2'd2;
	localparam logic [1:0] DIR_LEFT  = 2'd3;

	// Per-byte memory operation issued by the sequencer
	typedef enum logic [2:0] {
		OP_NOP,
		OP_WRITE,
		OP_READ,
		OP_COPY,
		OP_ZERO,
		OP_SHR,
		OP_SHL
	} op_kind_t;

	typedef struct packed {
		logic              valid;
		op_kind_t          kind;
		logic              last;   // final op of an item, produces the result word
		logic              first;  // first byte of a row, clears the shift carry
		logic [EXT_AW-1:0] dst;
		logic [EXT_AW-1:0] src;
		logic [7:0]        wdata;
	} op_t;

endpackage

`default_nettype wire

### rtl/mfrs_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Read returns the old contents on a same-cycle write. No dependencies.
`default_nettype none

module mfrs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8192,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

### rtl/mfrs_exec.sv
// Execute stage: issues the frame store read, then modifies and writes back.
// Depends on mfrs_pkg; drives an mfrs_ram instance held by the top level.
`default_nettype none

module mfrs_exec #(
	parameter int DEPTH = 8192,
	parameter int MAW = 13
) (
	input  logic           clk,
	input  logic           arst_n,
	input  mfrs_pkg::op_t  op,
	output logic [MAW-1:0] ram_raddr,
	input  logic [7:0]     ram_rdata,
	output logic           ram_we,
	output logic [MAW-1:0] ram_waddr,
	output logic [7:0]     ram_wdata,
	output logic           res_valid,
	output logic [7:0]     res_byte
);
	import mfrs_pkg::*;

	localparam logic [EXT_AW:0] DEPTH_X = (EXT_AW + 1)'(DEPTH);

	op_t        op_s1;
	logic       src_ok_s1;
	logic       fwd_s1;
	logic [7:0] fwd_data_s1;
	logic       carry_q;
	logic       fwd_hit;
	logic       dst_ok;
	logic       cin;
	logic [7:0] d;

	// Read issue; a write landing on the same entry this cycle is forwarded
	assign ram_raddr = op.src[MAW-1:0];
	assign fwd_hit   = op.valid && ram_we && (op_s1.dst == op.src);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1       <= '0;
			src_ok_s1   <= 1'b0;
			fwd_s1      <= 1'b0;
			fwd_data_s1 <= '0;
			carry_q     <= 1'b0;
		end else begin
			op_s1       <= op;
			src_ok_s1   <= {1'b0, op.src} < DEPTH_X;
			fwd_s1      <= fwd_hit;
			fwd_data_s1 <= ram_wdata;
			if (op_s1.valid && op_s1.kind == OP_SHR) begin
				carry_q <= d[0];
			end else if (op_s1.valid && op_s1.kind == OP_SHL) begin
				carry_q <= d[7];
			end
		end
	end

	// Source byte: zero beyond the store, forwarded data, or memory data
	always_comb begin
		if (!src_ok_s1) begin
			d = 8'd0;
		end else if (fwd_s1) begin
			d = fwd_data_s1;
		end else begin
			d = ram_rdata;
		end
	end

	assign cin    = op_s1.first ? 1'b0 : carry_q;
	assign dst_ok = {1'b0, op_s1.dst} < DEPTH_X;

	// Modify and write back
	always_comb begin
		ram_we    = 1'b0;
		ram_wdata = 8'd0;
		unique case (op_s1.kind)
			OP_WRITE: begin
				ram_we    = 1'b1;
				ram_wdata = op_s1.wdata;
			end
			OP_COPY: begin
				ram_we    = 1'b1;
				ram_wdata = d;
			end
			OP_ZERO: begin
				ram_we    = 1'b1;
				ram_wdata = 8'd0;
			end
			OP_SHR: begin
				ram_we    = 1'b1;
				ram_wdata = {cin, d[7:1]};
			end
			OP_SHL: begin
				ram_we    = 1'b1;
				ram_wdata = {d[6:0], cin};
			end
			default: begin
				ram_we    = 1'b0;
				ram_wdata = 8'd0;
			end
		endcase
		ram_we = ram_we && op_s1.valid && dst_ok;
	end

	assign ram_waddr = op_s1.dst[MAW-1:0];

	// Result word leaves with the final op of each item
	assign res_valid = op_s1.valid && op_s1.last;
	assign res_byte  = (op_s1.kind == OP_READ) ? d : 8'd0;

endmodule

`default_nettype wire

### rtl/mfrs_seq.sv
// Sequencer: takes input words and issues one frame store op per cycle, save
// while it waits for output queue room or sets up a scroll. Byte accesses
// issue at once; scrolls walk the region row by row. Depends on mfrs_pkg.
`default_nettype none

module mfrs_seq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [5:0]    row_bytes,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [1:0]    mode,
	input  logic [12:0]   byte_address,
	input  logic [7:0]    write_byte,
	input  logic [7:0]    region_left,
	input  logic [7:0]    region_top,
	input  logic [8:0]    region_width,
	input  logic [8:0]    region_height,
	input  logic [1:0]    direction,
	input  logic          space_ok,
	output mfrs_pkg::op_t op
);
	import mfrs_pkg::*;

	typedef enum logic [2:0] {S_IDLE, S_SETUP, S_BASE, S_RUN, S_END} state_t;

	state_t            state_q;
	logic [1:0]        dir_q;
	logic [5:0]        start_q;
	logic [6:0]        span_q;
	logic [8:0]        height_q;
	logic [7:0]        top_q;
	logic [15:0]       mul_q;
	logic [EXT_AW-1:0] base_q;
	logic [EXT_AW-1:0] src_base_q;
	logic [8:0]        rows_q;
	logic [5:0]        col_q;
	logic              first_q;

	logic [EXT_AW-1:0] stride;
	logic [9:0]        first_row;
	logic [8:0]        left_sum;
	logic [9:0]        width_sum;
	logic              row_end;
	logic              vertical;

	assign stride    = EXT_AW'(row_bytes);
	assign left_sum  = {1'b0, region_left} + 9'd7;
	assign width_sum = {1'b0, region_width} + 10'd7;
	assign vertical  = (dir_q == DIR_UP) || (dir_q == DIR_DOWN);
	assign first_row = (dir_q == DIR_DOWN) ? (10'(top_q) + 10'(height_q) - 10'd1)
	                                       : 10'(top_q);
	assign row_end   = (dir_q == DIR_LEFT) ? (col_q == 6'd0)
	                                       : (col_q == 6'(span_q - 7'd1));

	// Op issue
	always_comb begin
		op       = '0;
		op.kind  = OP_NOP;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = space_ok;
				op.dst   = EXT_AW'(byte_address);
				op.src   = EXT_AW'(byte_address);
				op.wdata = write_byte;
				op.last  = 1'b1;
				case (mode)
					MODE_WRITE:  op.kind = OP_WRITE;
					MODE_READ:   op.kind = OP_READ;
					MODE_SCROLL: op.last = 1'b0;
					default:     op.kind = OP_NOP;
				endcase
				op.valid = in_valid && space_ok && (mode != MODE_SCROLL);
			end
			S_RUN: begin
				op.valid = 1'b1;
				op.first = first_q;
				op.dst   = base_q + EXT_AW'(col_q);
				op.src   = src_base_q + EXT_AW'(col_q);
				if (vertical && rows_q == 9'd1) begin
					op.kind = OP_ZERO;
				end else begin
					unique case (dir_q)
						DIR_UP:    op.kind = OP_COPY;
						DIR_DOWN:  op.kind = OP_COPY;
						DIR_RIGHT: op.kind = OP_SHR;
						DIR_LEFT:  op.kind = OP_SHL;
					endcase
				end
			end
			S_END: begin
				op.valid = space_ok;
				op.last  = 1'b1;
			end
			default: begin
				op.valid = 1'b0;
			end
		endcase
	end

	// State and walk registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			dir_q      <= '0;
			start_q    <= '0;
			span_q     <= '0;
			height_q   <= '0;
			top_q      <= '0;
			mul_q      <= '0;
			base_q     <= '0;
			src_base_q <= '0;
			rows_q     <= '0;
			col_q      <= '0;
			first_q    <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && space_ok && mode == MODE_SCROLL) begin
						dir_q    <= direction;
						start_q  <= 6'(left_sum >> 3);
						span_q   <= 7'(width_sum >> 3);
						height_q <= region_height;
						top_q    <= region_top;
						state_q  <= S_SETUP;
					end
				end
				S_SETUP: begin
					mul_q <= 16'(row_bytes) * 16'(first_row);
					if (height_q == 9'd0 || span_q == 7'd0) begin
						state_q <= S_END;
					end else begin
						state_q <= S_BASE;
					end
				end
				S_BASE: begin
					base_q <= EXT_AW'(mul_q) + EXT_AW'(start_q);
					unique case (dir_q)
						DIR_UP:   src_base_q <= EXT_AW'(mul_q) + EXT_AW'(start_q) + stride;
						DIR_DOWN: src_base_q <= EXT_AW'(mul_q) + EXT_AW'(start_q) - stride;
						default:  src_base_q <= EXT_AW'(mul_q) + EXT_AW'(start_q);
					endcase
					rows_q  <= height_q;
					col_q   <= (dir_q == DIR_LEFT) ? 6'(span_q - 7'd1) : 6'd0;
					first_q <= 1'b1;
					state_q <= S_RUN;
				end
				S_RUN: begin
					if (row_end) begin
						first_q <= 1'b1;
						col_q   <= (dir_q == DIR_LEFT) ? 6'(span_q - 7'd1) : 6'd0;
						rows_q  <= rows_q - 9'd1;
						if (dir_q == DIR_DOWN) begin
							base_q     <= base_q - stride;
							src_base_q <= src_base_q - stride;
						end else begin
							base_q     <= base_q + stride;
							src_base_q <= src_base_q + stride;
						end
						if (rows_q == 9'd1) begin
							state_q <= S_END;
						end
					end else begin
						first_q <= 1'b0;
						col_q   <= (dir_q == DIR_LEFT) ? (col_q - 6'd1) : (col_q + 6'd1);
					end
				end
				S_END: begin
					if (space_ok) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

### rtl/mono_framebuffer_region_scroll_top.sv
// Top level of the monochrome frame store with region scroll.
// Depends on mfrs_pkg, mfrs_ram, mfrs_exec and mfrs_seq.
//
// One-bit-per-pixel frame store of MAX_ROW_BYTES * MAX_ROWS bytes, leftmost
// pixel in the MSB, rows row_bytes apart. Each input word writes a byte, reads
// a byte or scrolls a region by one step; each gives one output word
// (read_byte, zero unless a read). Byte writes and reads are taken one per
// cycle while the two-word output queue has room; the result word is
// registered in the execute stage and then in the output queue. A scroll
// walks the region one byte per cycle through the store's one read and one
// write port, after setup and row-base multiply steps and before a closing
// step; the next word is taken once it ends. The store is not cleared at
// reset; load it before reading or scrolling.
`default_nettype none

module mono_framebuffer_region_scroll_top #(
	parameter int MAX_ROW_BYTES = 32,
	parameter int MAX_ROWS = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [5:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [12:0] byte_address,
	input  logic [7:0]  write_byte,
	input  logic [7:0]  region_left,
	input  logic [7:0]  region_top,
	input  logic [8:0]  region_width,
	input  logic [8:0]  region_height,
	input  logic [1:0]  direction,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  read_byte
);
	import mfrs_pkg::*;

	localparam int DEPTH = MAX_ROW_BYTES * MAX_ROWS;
	localparam int MAW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [5:0]     row_bytes_q;
	op_t            op;
	logic           space_ok;
	logic [MAW-1:0] ram_raddr;
	logic [MAW-1:0] ram_waddr;
	logic [7:0]     ram_rdata;
	logic [7:0]     ram_wdata;
	logic           ram_we;
	logic           res_valid;
	logic [7:0]     res_byte;

	logic [7:0]     fifo_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     cnt_q;
	logic           pop;
	logic [2:0]     occ;

	// Row distance register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_bytes_q <= 6'd32;
		end else if (cfg_we) begin
			row_bytes_q <= cfg_wdata;
		end
	end

	// A word may enter only if its result will find room in the output queue
	assign pop      = out_valid && out_ready;
	assign occ      = 3'(cnt_q) + 3'(res_valid);
	assign space_ok = occ < (3'd2 + 3'(pop));

	mfrs_seq u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.row_bytes     (row_bytes_q),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.mode          (mode),
		.byte_address  (byte_address),
		.write_byte    (write_byte),
		.region_left   (region_left),
		.region_top    (region_top),
		.region_width  (region_width),
		.region_height (region_height),
		.direction     (direction),
		.space_ok      (space_ok),
		.op            (op)
	);

	mfrs_exec #(
		.DEPTH (DEPTH),
		.MAW   (MAW)
	) u_exec (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.res_valid (res_valid),
		.res_byte  (res_byte)
	);

	mfrs_ram #(
		.WIDTH (8),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Two-word output queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (res_valid) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(res_valid) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			fifo_q[wr_ptr_q] <= res_byte;
		end
	end

	assign out_valid = (cnt_q != 2'd0);
	assign read_byte = fifo_q[rd_ptr_q];

endmodule

`default_nettype wire
